// ===== rtl/core/array_linked_list_engine_core_defines.svh =====
// Assertion macros shared by the linked list engine modules.
// Each macro expects signals named clock and reset in the calling module.
`ifndef ARRAY_LINKED_LIST_ENGINE_CORE_DEFINES_SVH
`define ARRAY_LINKED_LIST_ENGINE_CORE_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define ALLE_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define ALLE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define ALLE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/alle_pkg.sv =====
`timescale 1ns / 1ps

package alle_pkg;

   // Table geometry. Only slots below USED take part in any operation.
   localparam int NODES = 16;
   localparam int DEPTH = 16;
   localparam int USED  = (NODES < DEPTH) ? NODES : DEPTH;

   // Field widths.
   localparam int OP_W   = 3;
   localparam int SLOT_W = 4;
   localparam int KEY_W  = 31;
   localparam int STAT_W = 16;
   localparam int CODE_W = 3;
   localparam int POS_W  = 5;
   localparam int CNT_W  = 5;

   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 64;

   localparam logic [CNT_W-1:0] USED_CNT  = CNT_W'(USED);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   // Operation codes.
   localparam logic [OP_W-1:0] OP_LOAD   = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
   localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
   localparam logic [OP_W-1:0] OP_LIST   = 3'd4;

   // Result codes.
   localparam logic [CODE_W-1:0] RC_DONE   = 3'd0;
   localparam logic [CODE_W-1:0] RC_RECORD = 3'd1;
   localparam logic [CODE_W-1:0] RC_MISS   = 3'd2;
   localparam logic [CODE_W-1:0] RC_LIMIT  = 3'd3;
   localparam logic [CODE_W-1:0] RC_REJECT = 3'd4;

   // Source of the payload loaded into the result register.
   localparam logic [1:0] ES_PLAIN = 2'd0;
   localparam logic [1:0] ES_WALK  = 2'd1;
   localparam logic [1:0] ES_PEND  = 2'd2;
   localparam logic [1:0] ES_INS   = 2'd3;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [STAT_W-1:0] status;
      logic [SLOT_W-1:0] slot;
      logic [SLOT_W-1:0] link;
      logic [POS_W-1:0]  pos;
   } record_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              capture;
      logic              load_wr;
      logic              ins_init;
      logic              ins_rd;
      logic              ins_next;
      logic              ins_commit;
      logic              walk_init;
      logic              walk_adv;
      logic              del_commit;
      logic              pend_load;
      logic              pend_clear;
      logic              emit;
      logic [1:0]        emit_sel;
      logic [CODE_W-1:0] emit_code;
      logic              emit_last;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            load_bad;
      logic            walk_end;
      logic            cur_zero;
      logic            ins_end;
      logic            walk_hit;
      logic            anchor_hit;
      logic            free_found;
      logic            pend_valid;
      logic            rec_full;
      logic            out_free;
   } stat_type;

endpackage

// ===== rtl/core/alle_dpath.sv =====
`timescale 1ns / 1ps
`include "array_linked_list_engine_core_defines.svh"

module alle_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   // slot, key, anchor_key, entry_status, link_slot, set_head, zero pad
   input  logic [alle_pkg::REQ_DATA_W-1:0]      req_tdata,
   // operation
   input  logic [alle_pkg::OP_W-1:0]            req_tuser,
   input  alle_pkg::cmd_type                    cmd,
   output alle_pkg::stat_type                   stat,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // found_key, found_status, found_slot, found_link, position, zero pad
   output logic [alle_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // code
   output logic [alle_pkg::CODE_W-1:0]          rsp_tuser,
   output logic                                 rsp_tlast
);

   localparam int SLOT_W = alle_pkg::SLOT_W;
   localparam int KEY_W  = alle_pkg::KEY_W;
   localparam int STAT_W = alle_pkg::STAT_W;
   localparam int CNT_W  = alle_pkg::CNT_W;
   localparam int DEPTH  = alle_pkg::DEPTH;

   // Captured input item.
   logic [alle_pkg::OP_W-1:0] op_ff;
   logic [SLOT_W-1:0]         slot_ff;
   logic [KEY_W-1:0]          key_ff;
   logic [KEY_W-1:0]          anchor_ff;
   logic [STAT_W-1:0]         status_ff;
   logic [SLOT_W-1:0]         item_link_ff;
   logic                      set_head_ff;

   // Slot table: keys and status words in memory, links and valid marks in flops.
   logic [KEY_W-1:0]          mem_key  [DEPTH];
   logic [STAT_W-1:0]         mem_stat [DEPTH];
   logic [KEY_W-1:0]          rd_key_ff;
   logic [STAT_W-1:0]         rd_stat_ff;
   logic [SLOT_W-1:0]         link_ff  [DEPTH];
   logic [DEPTH-1:0]          valid_ff;
   logic [SLOT_W-1:0]         head_ff;

   // Walk and scan registers.
   logic [SLOT_W-1:0]         cur_ff, cur_in;
   logic [SLOT_W-1:0]         prev_ff, prev_in;
   logic [CNT_W-1:0]          steps_ff, steps_in;
   logic [CNT_W-1:0]          ins_idx_ff, ins_idx_in;
   logic [CNT_W-1:0]          rec_cnt_ff, rec_cnt_in;
   alle_pkg::record_type      pend_ff, pend_in;
   logic                      pend_valid_ff, pend_valid_in;

   // Result register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [alle_pkg::CODE_W-1:0] rsp_code_ff, rsp_code_in;
   alle_pkg::record_type      rsp_rec_ff, rsp_rec_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic [SLOT_W-1:0]         rd_addr;
   logic [SLOT_W-1:0]         ins_slot;
   logic [SLOT_W-1:0]         cur_link;
   logic [SLOT_W-1:0]         cur_next;
   logic                      free_found;
   logic [SLOT_W-1:0]         free_slot;
   logic                      mem_wr;
   logic [SLOT_W-1:0]         mem_wr_addr;
   alle_pkg::record_type      walk_rec;
   alle_pkg::record_type      ins_rec;
   logic                      out_free;

   // Input item capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff        <= req_tuser;
         slot_ff      <= req_tdata[3:0];
         key_ff       <= req_tdata[34:4];
         anchor_ff    <= req_tdata[65:35];
         status_ff    <= req_tdata[81:66];
         item_link_ff <= req_tdata[85:82];
         set_head_ff  <= req_tdata[86];
      end
   end

   // Link of the current slot, and the link followed, where an out-of-range link ends the list.
   assign ins_slot = ins_idx_ff[SLOT_W-1:0];
   assign cur_link = link_ff[cur_ff];
   assign cur_next = ({1'b0, cur_link} < alle_pkg::USED_CNT) ? cur_link : '0;

   // Lowest free slot above the anchor slot.
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int j = DEPTH - 1; j >= 1; j--) begin
         if ((CNT_W'(j) > ins_idx_ff) && (j < alle_pkg::USED) && !valid_ff[j]) begin
            free_found = 1'b1;
            free_slot  = SLOT_W'(j);
         end
      end
   end

   // Memory port: one write, one registered read.
   assign rd_addr     = cmd.ins_rd ? ins_slot : cur_ff;
   assign mem_wr      = cmd.load_wr | cmd.ins_commit;
   assign mem_wr_addr = cmd.load_wr ? slot_ff : free_slot;

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem_key[mem_wr_addr]  <= key_ff;
         mem_stat[mem_wr_addr] <= status_ff;
      end
      rd_key_ff  <= mem_key[rd_addr];
      rd_stat_ff <= mem_stat[rd_addr];
   end

   // Links, valid marks and head. A later write in this block wins, so a
   // deleted slot always ends with a cleared link.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            link_ff[i] <= '0;
         end
         valid_ff <= '0;
         head_ff  <= '0;
      end else begin
         if (cmd.load_wr) begin
            link_ff[slot_ff]  <= item_link_ff;
            valid_ff[slot_ff] <= 1'b1;
            if (set_head_ff) begin
               head_ff <= slot_ff;
            end
         end
         if (cmd.ins_commit) begin
            link_ff[free_slot]  <= link_ff[ins_slot];
            link_ff[ins_slot]   <= free_slot;
            valid_ff[free_slot] <= 1'b1;
         end
         if (cmd.del_commit) begin
            if (prev_ff == '0) begin
               head_ff <= cur_next;
            end else begin
               link_ff[prev_ff] <= cur_link;
            end
            valid_ff[cur_ff] <= 1'b0;
            link_ff[cur_ff]  <= '0;
         end
      end
   end

   // Records that can be reported.
   always_comb begin
      walk_rec.key    = rd_key_ff;
      walk_rec.status = rd_stat_ff;
      walk_rec.slot   = cur_ff;
      walk_rec.link   = cur_link;
      walk_rec.pos    = steps_ff + CNT_W'(1);
      ins_rec.key     = key_ff;
      ins_rec.status  = status_ff;
      ins_rec.slot    = free_slot;
      ins_rec.link    = link_ff[ins_slot];
      ins_rec.pos     = '0;
   end

   // Walk, scan and pending-record next values.
   always_comb begin
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      steps_in      = steps_ff;
      ins_idx_in    = ins_idx_ff;
      rec_cnt_in    = rec_cnt_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      if (cmd.walk_init) begin
         cur_in        = head_ff;
         prev_in       = '0;
         steps_in      = '0;
         rec_cnt_in    = '0;
         pend_valid_in = 1'b0;
      end
      if (cmd.walk_adv) begin
         prev_in  = cur_ff;
         cur_in   = cur_next;
         steps_in = steps_ff + CNT_W'(1);
      end
      if (cmd.pend_load) begin
         pend_in       = walk_rec;
         pend_valid_in = 1'b1;
         rec_cnt_in    = rec_cnt_ff + CNT_W'(1);
      end
      if (cmd.pend_clear) begin
         pend_valid_in = 1'b0;
      end
      if (cmd.ins_init) begin
         ins_idx_in = CNT_W'(1);
      end
      if (cmd.ins_next) begin
         ins_idx_in = ins_idx_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
      cur_ff     <= cur_in;
      prev_ff    <= prev_in;
      steps_ff   <= steps_in;
      ins_idx_ff <= ins_idx_in;
      rec_cnt_ff <= rec_cnt_in;
      pend_ff    <= pend_in;
   end

   // Result register: loaded on emit, emptied when the transaction completes.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_code_in  = rsp_code_ff;
      rsp_rec_in   = rsp_rec_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = cmd.emit_code;
         rsp_last_in  = cmd.emit_last;
         case (cmd.emit_sel)
            alle_pkg::ES_PLAIN: rsp_rec_in = '0;
            alle_pkg::ES_WALK:  rsp_rec_in = walk_rec;
            alle_pkg::ES_PEND:  rsp_rec_in = pend_ff;
            alle_pkg::ES_INS:   rsp_rec_in = ins_rec;
            default:            rsp_rec_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_code_ff <= rsp_code_in;
      rsp_rec_ff  <= rsp_rec_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_code_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'b0000, rsp_rec_ff.pos, rsp_rec_ff.link, rsp_rec_ff.slot,
                        rsp_rec_ff.status, rsp_rec_ff.key};

   // Status towards the controller.
   always_comb begin
      stat.op         = op_ff;
      stat.load_bad   = (slot_ff == '0) || ({1'b0, slot_ff} >= alle_pkg::USED_CNT);
      stat.cur_zero   = (cur_ff == '0);
      stat.walk_end   = (cur_ff == '0) || (steps_ff == alle_pkg::USED_CNT);
      stat.ins_end    = (ins_idx_ff >= alle_pkg::USED_CNT);
      stat.walk_hit   = valid_ff[cur_ff] &&
                        ((op_ff == alle_pkg::OP_LIST) || (rd_key_ff == key_ff));
      stat.anchor_hit = valid_ff[ins_slot] && (rd_key_ff == anchor_ff);
      stat.free_found = free_found;
      stat.pend_valid = pend_valid_ff;
      stat.rec_full   = (rec_cnt_ff == alle_pkg::DEPTH_CNT);
      stat.out_free   = out_free;
   end

   // The null slot can never hold an entry, the head never points outside the
   // used slots, and a result is never loaded over one still waiting.
   `ALLE_ASSERT_ALWAYS(a_null_slot_free, !valid_ff[0], "slot 0 marked valid")
   `ALLE_ASSERT_ALWAYS(a_head_in_range, {1'b0, head_ff} < alle_pkg::USED_CNT, "head out of range")
   `ALLE_ASSERT_SAME(a_emit_free, cmd.emit, out_free, "result overwritten")

endmodule

// ===== rtl/core/alle_ctrl.sv =====
`timescale 1ns / 1ps
`include "array_linked_list_engine_core_defines.svh"

module alle_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  alle_pkg::stat_type  stat,
   output alle_pkg::cmd_type   cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DISPATCH = 3'd1;
   localparam logic [2:0] ST_INS_RD   = 3'd2;
   localparam logic [2:0] ST_INS_CMP  = 3'd3;
   localparam logic [2:0] ST_WALK_RD  = 3'd4;
   localparam logic [2:0] ST_WALK_CMP = 3'd5;
   localparam logic [2:0] ST_WALK_END = 3'd6;
   localparam logic [2:0] ST_LIMIT    = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   // Sequencer: one operation at a time, each walk step is a read then a compare.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (stat.op)
               alle_pkg::OP_LOAD: begin
                  if (stat.out_free) begin
                     cmd.emit      = 1'b1;
                     cmd.emit_sel  = alle_pkg::ES_PLAIN;
                     cmd.emit_code = stat.load_bad ? alle_pkg::RC_REJECT : alle_pkg::RC_DONE;
                     cmd.emit_last = 1'b1;
                     cmd.load_wr   = !stat.load_bad;
                     state_in      = ST_IDLE;
                  end
               end
               alle_pkg::OP_INSERT: begin
                  cmd.ins_init = 1'b1;
                  state_in     = ST_INS_RD;
               end
               alle_pkg::OP_DELETE, alle_pkg::OP_SEARCH, alle_pkg::OP_LIST: begin
                  cmd.walk_init = 1'b1;
                  state_in      = ST_WALK_RD;
               end
               default: begin
                  if (stat.out_free) begin
                     cmd.emit      = 1'b1;
                     cmd.emit_sel  = alle_pkg::ES_PLAIN;
                     cmd.emit_code = alle_pkg::RC_REJECT;
                     cmd.emit_last = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end
            endcase
         end
         ST_INS_RD: begin
            if (stat.ins_end) begin
               if (stat.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_sel  = alle_pkg::ES_PLAIN;
                  cmd.emit_code = alle_pkg::RC_MISS;
                  cmd.emit_last = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else begin
               cmd.ins_rd = 1'b1;
               state_in   = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            // The first anchor decides: no free slot above it means none above later ones.
            if (stat.anchor_hit) begin
               if (stat.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_last = 1'b1;
                  if (stat.free_found) begin
                     cmd.ins_commit = 1'b1;
                     cmd.emit_sel   = alle_pkg::ES_INS;
                     cmd.emit_code  = alle_pkg::RC_DONE;
                  end else begin
                     cmd.emit_sel   = alle_pkg::ES_PLAIN;
                     cmd.emit_code  = alle_pkg::RC_MISS;
                  end
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.ins_next = 1'b1;
               state_in     = ST_INS_RD;
            end
         end
         ST_WALK_RD: begin
            state_in = stat.walk_end ? ST_WALK_END : ST_WALK_CMP;
         end
         ST_WALK_CMP: begin
            if (stat.walk_hit && (stat.op == alle_pkg::OP_DELETE)) begin
               if (stat.out_free) begin
                  cmd.emit       = 1'b1;
                  cmd.emit_sel   = alle_pkg::ES_WALK;
                  cmd.emit_code  = alle_pkg::RC_DONE;
                  cmd.emit_last  = 1'b1;
                  cmd.del_commit = 1'b1;
                  state_in       = ST_IDLE;
               end
            end else if (stat.walk_hit) begin
               // A record is held back one match so that the final one can carry last.
               if (!stat.pend_valid) begin
                  cmd.pend_load = 1'b1;
                  cmd.walk_adv  = 1'b1;
                  state_in      = ST_WALK_RD;
               end else if (stat.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_sel  = alle_pkg::ES_PEND;
                  cmd.emit_code = alle_pkg::RC_RECORD;
                  cmd.pend_load = 1'b1;
                  cmd.walk_adv  = 1'b1;
                  state_in      = ST_WALK_RD;
               end
            end else begin
               cmd.walk_adv = 1'b1;
               state_in     = ST_WALK_RD;
            end
         end
         ST_WALK_END: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_sel  = alle_pkg::ES_PLAIN;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
               if (stat.op == alle_pkg::OP_DELETE) begin
                  cmd.emit_code = stat.cur_zero ? alle_pkg::RC_MISS : alle_pkg::RC_LIMIT;
               end else if (!stat.cur_zero) begin
                  // Walk limit: a full record set loses its last record to the limit code.
                  if (stat.pend_valid && !stat.rec_full) begin
                     cmd.emit_sel   = alle_pkg::ES_PEND;
                     cmd.emit_code  = alle_pkg::RC_RECORD;
                     cmd.emit_last  = 1'b0;
                     cmd.pend_clear = 1'b1;
                     state_in       = ST_LIMIT;
                  end else begin
                     cmd.emit_code  = alle_pkg::RC_LIMIT;
                  end
               end else if (stat.pend_valid) begin
                  cmd.emit_sel  = alle_pkg::ES_PEND;
                  cmd.emit_code = alle_pkg::RC_RECORD;
               end else begin
                  cmd.emit_code = (stat.op == alle_pkg::OP_LIST) ? alle_pkg::RC_DONE
                                                                  : alle_pkg::RC_MISS;
               end
            end
         end
         ST_LIMIT: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_sel  = alle_pkg::ES_PLAIN;
               cmd.emit_code = alle_pkg::RC_LIMIT;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The final result of an item always hands control back for the next item.
   `ALLE_ASSERT_NEXT(a_last_to_idle, cmd.emit && cmd.emit_last, state_ff == ST_IDLE, "last without idle")

endmodule

// ===== rtl/core/array_linked_list_engine_core.sv =====
// Array-based singly linked list engine over a table of 16 slots.
// Request channel (req_): one transaction carries one operation in req_tuser
// (load, insert after anchor, delete, search, list) and its operands in req_tdata.
// Response channel (rsp_): one or more transactions per request; rsp_tuser holds
// the result code, rsp_tdata the reported entry and its position, and rsp_tlast
// marks the final response of the request.
// Requests are handled one at a time: req_tready is high only while the engine
// is idle. Load and rejected operations are answered from the dispatch step.
// Delete, search and list walk the list one link at a time, each step a key
// memory read then a compare, following up to 16 links. Insert scans the slots
// for the anchor in the same way, read then compare, over at most 15 slots.
// Both loops go through the single key memory read port.
// Reset clears every valid mark, every link and the head at once; the engine
// accepts a request in the first cycle after reset.
// A stalled response channel holds the engine at any step that emits a result;
// the result register keeps its transaction stable until rsp_tready is seen.
`timescale 1ns / 1ps

module array_linked_list_engine_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // slot, key, anchor_key, entry_status, link_slot, set_head, zero pad
   input  logic [alle_pkg::REQ_DATA_W-1:0]      req_tdata,
   // operation
   input  logic [alle_pkg::OP_W-1:0]            req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // found_key, found_status, found_slot, found_link, position, zero pad
   output logic [alle_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // code
   output logic [alle_pkg::CODE_W-1:0]          rsp_tuser,
   output logic                                 rsp_tlast
);

   alle_pkg::cmd_type  cmd;
   alle_pkg::stat_type stat;

   // Operation sequencer.
   alle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Slot table, walk registers and result register.
   alle_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
